>>> src/rgb_crossfade_pwm_defines.svh
// Assertion macros shared by the cross-fade PWM RTL.
`ifndef RGB_CROSSFADE_PWM_DEFINES_SVH
`define RGB_CROSSFADE_PWM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RCF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> src/rcf_pkg.sv
// Types and constants shared by the cross-fade PWM modules.
`timescale 1ns / 1ps

package rcf_pkg;

    localparam logic [7:0]  DUTY_FULL        = 8'hFF;
    localparam logic [15:0] PHASE_LEN_RESET  = 16'd10000;

    // Cross-fade phases.
    localparam logic [1:0]  PHASE_RG = 2'd0;
    localparam logic [1:0]  PHASE_GB = 2'd1;
    localparam logic [1:0]  PHASE_BR = 2'd2;

    typedef struct packed {
        logic        start;
        logic [23:0] num;
        logic [15:0] den;
    } t_div_req;

    typedef struct packed {
        logic       done;
        logic [7:0] quot;
    } t_div_rsp;

endpackage

>>> src/rcf_div.sv
// Restoring divider, one quotient bit per cycle, for quotients below 256.
`timescale 1ns / 1ps
`include "rgb_crossfade_pwm_defines.svh"

module rcf_div
    import rcf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy;
    logic [2:0]  r_cnt;
    logic [15:0] r_rem;
    logic [7:0]  r_num_lo;
    logic [7:0]  r_quot;
    logic [15:0] r_den;

    logic [16:0] trial;
    logic [16:0] diff;
    logic        ge;
    logic [15:0] n_rem;

    // The upper numerator bits are below the divisor, so eight steps suffice.
    assign trial = {r_rem, r_num_lo[7]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});
    assign n_rem = ge ? diff[15:0] : trial[15:0];

    assign o_rsp.done = r_busy && (r_cnt == 3'd7);
    assign o_rsp.quot = {r_quot[6:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= 3'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem    <= i_req.num[23:8];
            r_num_lo <= i_req.num[7:0];
            r_den    <= i_req.den;
            r_quot   <= 8'd0;
        end else if (r_busy) begin
            r_rem    <= n_rem;
            r_num_lo <= {r_num_lo[6:0], 1'b0};
            r_quot   <= {r_quot[6:0], ge};
        end
    end

    `RCF_ASSERT_NOW(a_start_idle, i_clk, i_rst_n, i_req.start, !r_busy)
    `RCF_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_req.start, r_busy && (r_cnt == 3'd0))
    `RCF_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_rsp.done, !r_busy)

endmodule

>>> src/rgb_crossfade_pwm.sv
// Top level of the three-channel cross-fade PWM.
//
// Input channel: i_valid / o_stall carry one word per tick (i_tick). A word is
// taken at a clock edge with i_valid high and o_stall low. A word whose tick
// bit is zero is taken and dropped: no result, no state change.
// Output channel: o_valid / i_stall carry one result per tick word: the red,
// green and blue on flags and the fade phase in force at that tick.
// The result is registered and shows on o_valid the cycle after acceptance.
// After a tick word the block refreshes the duties (setup state S_START, then
// 8 steps of the restoring divider in S_DIV, one quotient bit a cycle) and
// stalls new words until the refresh is done and it is back in S_IDLE.
// While a result waits under i_stall, the block holds it and stalls new words
// until it is taken. i_cfg_we writes phase_length at once; write only while
// idle. Synchronous active-low reset restores the default phase length of
// 10000, red fully on, green and blue off, counters and phase at zero.
`timescale 1ns / 1ps
`include "rgb_crossfade_pwm_defines.svh"

module rgb_crossfade_pwm
    import rcf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_tick,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_red_on,
    output logic        o_green_on,
    output logic        o_blue_on,
    output logic [1:0]  o_fade_phase
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_DIV
    } t_state;

    t_state      r_state;
    logic [15:0] r_phase_len;
    logic [7:0]  r_pwm_cnt;
    logic [7:0]  r_red_duty;
    logic [7:0]  r_green_duty;
    logic [7:0]  r_blue_duty;
    logic [15:0] r_elapsed;
    logic [1:0]  r_phase;
    logic [15:0] r_len;
    logic        r_sat;
    logic        r_out_valid;
    logic        r_red_on;
    logic        r_green_on;
    logic        r_blue_on;
    logic [1:0]  r_out_phase;

    logic        in_take;
    logic        tick_take;
    logic        out_take;
    logic [15:0] len_eff;
    t_div_req    div_req;
    t_div_rsp    div_rsp;
    logic [7:0]  rising;
    logic [7:0]  falling;
    logic [16:0] next_elapsed;
    logic        phase_end;

    assign o_stall   = (r_state != S_IDLE) || (r_out_valid && i_stall);
    assign in_take   = i_valid && !o_stall;
    assign tick_take = in_take && i_tick;
    assign out_take  = r_out_valid && !i_stall;

    // A zero phase length behaves as one.
    assign len_eff = (r_phase_len == 16'd0) ? 16'd1 : r_phase_len;

    // elapsed * 255 as one subtract.
    assign div_req.start = (r_state == S_START);
    assign div_req.num   = {r_elapsed, 8'd0} - {8'd0, r_elapsed};
    assign div_req.den   = r_len;

    rcf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign rising       = r_sat ? DUTY_FULL : div_rsp.quot;
    assign falling      = DUTY_FULL - rising;
    assign next_elapsed = {1'b0, r_elapsed} + 17'd1;
    assign phase_end    = (next_elapsed >= {1'b0, r_len});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_len <= PHASE_LEN_RESET;
        end else if (i_cfg_we) begin
            r_phase_len <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pwm_cnt    <= 8'd0;
            r_red_duty   <= DUTY_FULL;
            r_green_duty <= 8'd0;
            r_blue_duty  <= 8'd0;
            r_elapsed    <= 16'd0;
            r_phase      <= PHASE_RG;
            r_out_valid  <= 1'b0;
        end else begin
            if (tick_take) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (tick_take) begin
                        r_pwm_cnt <= r_pwm_cnt + 8'd1;
                        r_state   <= S_START;
                    end
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        unique case (r_phase)
                            PHASE_RG: begin
                                r_red_duty   <= falling;
                                r_green_duty <= rising;
                                r_blue_duty  <= 8'd0;
                            end
                            PHASE_GB: begin
                                r_green_duty <= falling;
                                r_blue_duty  <= rising;
                                r_red_duty   <= 8'd0;
                            end
                            default: begin
                                r_blue_duty  <= falling;
                                r_red_duty   <= rising;
                                r_green_duty <= 8'd0;
                            end
                        endcase
                        if (phase_end) begin
                            r_elapsed <= 16'd0;
                            r_phase   <= (r_phase == PHASE_BR) ? PHASE_RG : r_phase + 2'd1;
                        end else begin
                            r_elapsed <= next_elapsed[15:0];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Snapshot the flags, phase, divisor and saturation flag for the tick just taken.
    always_ff @(posedge i_clk) begin
        if (tick_take) begin
            r_red_on    <= (r_pwm_cnt < r_red_duty);
            r_green_on  <= (r_pwm_cnt < r_green_duty);
            r_blue_on   <= (r_pwm_cnt < r_blue_duty);
            r_out_phase <= r_phase;
            r_len       <= len_eff;
            r_sat       <= (r_elapsed >= len_eff);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_red_on     = r_red_on;
    assign o_green_on   = r_green_on;
    assign o_blue_on    = r_blue_on;
    assign o_fade_phase = r_out_phase;

    `RCF_ASSERT_NOW(a_done_in_div, i_clk, i_rst_n, div_rsp.done, r_state == S_DIV)
    `RCF_ASSERT_NEXT(a_tick_gives_word, i_clk, i_rst_n, tick_take, o_valid && (r_state == S_START))
    `RCF_ASSERT_NOW(a_phase_legal, i_clk, i_rst_n, 1'b1, r_phase != 2'd3)

endmodule

>>> dv/rgb_crossfade_pwm_test.sv
// Testbench for the three-channel cross-fade PWM: directed and random ticks against a predictor.
`timescale 1ns / 1ps

module rgb_crossfade_pwm_test
    import rcf_pkg::*;
();

    localparam int IDLE_PCT    = 8;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_WAIT  = 20;
    localparam int RANDOM_TICKS = 600;

    typedef struct packed {
        logic       red;
        logic       green;
        logic       blue;
        logic [1:0] phase;
    } t_led_word;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_valid     = 1'b0;
    logic        i_tick      = 1'b0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_red_on;
    logic        o_green_on;
    logic        o_blue_on;
    logic [1:0]  o_fade_phase;

    // Predictor state
    logic [15:0] fade_len   = PHASE_LEN_RESET;
    logic [7:0]  pwm_count  = '0;
    logic [7:0]  duty_r     = DUTY_FULL;
    logic [7:0]  duty_g     = '0;
    logic [7:0]  duty_b     = '0;
    logic [15:0] fade_ticks = '0;
    logic [1:0]  fade_phase = PHASE_RG;

    t_led_word pending_leds[$];
    int        fail_count    = 0;
    bit        quiet_tx      = 1'b0;
    bit        quiet_rx      = 1'b0;
    int        hold_requests = 0;
    int        hold_seen     = 0;
    int        hold_left     = 0;

    rgb_crossfade_pwm i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_tick       (i_tick),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red_on     (o_red_on),
        .o_green_on   (o_green_on),
        .o_blue_on    (o_blue_on),
        .o_fade_phase (o_fade_phase)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic void advance_crossfade(input logic tick_bit);
        t_led_word   word;
        int unsigned len;
        int unsigned rising;
        int unsigned falling;
        int unsigned next_ticks;
        if (!tick_bit) return;
        word.red   = pwm_count < duty_r;
        word.green = pwm_count < duty_g;
        word.blue  = pwm_count < duty_b;
        word.phase = fade_phase;
        pending_leds.push_back(word);
        pwm_count = pwm_count + 8'd1;

        len = (fade_len == 0) ? 1 : fade_len;
        // saturate when the length was lowered to or below the elapsed count
        if (fade_ticks >= len) begin
            rising = DUTY_FULL;
        end else begin
            rising = (fade_ticks * DUTY_FULL) / len;
        end
        falling = DUTY_FULL - rising;

        case (fade_phase)
            PHASE_RG: begin
                duty_r = 8'(falling);
                duty_g = 8'(rising);
                duty_b = '0;
            end
            PHASE_GB: begin
                duty_g = 8'(falling);
                duty_b = 8'(rising);
                duty_r = '0;
            end
            default: begin
                duty_b = 8'(falling);
                duty_r = 8'(rising);
                duty_g = '0;
            end
        endcase

        next_ticks = fade_ticks + 1;
        if (next_ticks >= len) begin
            fade_ticks = '0;
            case (fade_phase)
                PHASE_RG: fade_phase = PHASE_GB;
                PHASE_GB: fade_phase = PHASE_BR;
                default:  fade_phase = PHASE_RG;
            endcase
        end else begin
            fade_ticks = 16'(next_ticks);
        end
    endfunction

    // Offer one word, with random gaps, and hold it until taken.
    task automatic send_word(input logic tick_bit);
        while (!quiet_tx && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            i_tick  <= 1'($urandom);
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_tick  <= tick_bit;
        do @(posedge i_clk); while (o_stall);
        advance_crossfade(tick_bit);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_leds.size() != 0) @(posedge i_clk);
        // let the duty refresh of the last tick finish
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_phase_length(input logic [15:0] len);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        fade_len = len;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 16'($urandom);
    endtask

    task automatic test_reset_state();
        send_word(1'b1);
        send_word(1'b0);
        repeat (3) send_word(1'b1);
    endtask

    task automatic test_unit_phases();
        set_phase_length(16'd1);
        repeat (5) send_word(1'b1);
        set_phase_length(16'd0);
        repeat (3) send_word(1'b1);
    endtask

    task automatic test_lowered_length();
        set_phase_length(16'hFFFF);
        repeat (4) send_word(1'b1);
        set_phase_length(16'd2);
        repeat (3) send_word(1'b1);
    endtask

    task automatic test_short_phase();
        set_phase_length(16'd3);
        send_word(1'b1);
        send_word(1'b0);
        repeat (4) send_word(1'b1);
    endtask

    task automatic test_back_to_back();
        set_phase_length(16'd7);
        quiet_tx = 1'b1;
        quiet_rx = 1'b1;
        repeat (100) send_word(1'b1);
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
    endtask

    task automatic test_output_backpressure();
        set_phase_length(16'd5);
        hold_requests++;
        repeat (12) send_word(1'b1);
    endtask

    task automatic test_random_fades();
        int          sent;
        int          pick;
        logic [15:0] len;
        logic        tick_bit;
        sent = 0;
        while (sent < RANDOM_TICKS) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                len = 16'($urandom_range(1, 12));
            end else if (pick < 78) begin
                len = 16'($urandom_range(13, 300));
            end else if (pick < 88) begin
                len = 16'($urandom);
            end else if (pick < 94) begin
                len = 16'hFFFF;
            end else begin
                len = 16'($urandom_range(0, 1));
            end
            set_phase_length(len);
            repeat ($urandom_range(20, 60)) begin
                tick_bit = ($urandom_range(9) != 0);
                send_word(tick_bit);
                if (tick_bit) sent++;
            end
        end
    endtask

    // Receiver: random stalls, plus a long hold when one is requested.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= quiet_rx ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_led_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_leds.size() == 0) begin
                $error("result word with nothing expected");
                fail_count++;
            end else begin
                want = pending_leds.pop_front();
                if (o_red_on !== want.red) begin
                    $error("red_on: expected %0d, got %0d", want.red, o_red_on);
                    fail_count++;
                end
                if (o_green_on !== want.green) begin
                    $error("green_on: expected %0d, got %0d", want.green, o_green_on);
                    fail_count++;
                end
                if (o_blue_on !== want.blue) begin
                    $error("blue_on: expected %0d, got %0d", want.blue, o_blue_on);
                    fail_count++;
                end
                if (o_fade_phase !== want.phase) begin
                    $error("fade_phase: expected %0d, got %0d", want.phase, o_fade_phase);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_unit_phases();
        test_lowered_length();
        test_short_phase();
        test_back_to_back();
        test_output_backpressure();
        test_random_fades();
        drain_results();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> rgb_crossfade_pwm.f
+incdir+src
src/rcf_pkg.sv
src/rcf_div.sv
src/rgb_crossfade_pwm.sv
dv/rgb_crossfade_pwm_test.sv
